// File: rtl/core/cksb_pkg.sv
// cksb_pkg: shared types and constants of the colour-keyed sprite blitter
// used by cksb_ctrl, cksb_dp and color_keyed_sprite_blitter
`default_nettype none

package cksb_pkg;

  // item kinds carried on the input tuser
  typedef enum logic [1:0] {
    MODE_BEGIN = 2'd0,
    MODE_PIXEL = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_READ  = 2'd3
  } mode_e;

  // draw kinds of a sprite
  typedef enum logic [1:0] {
    KIND_COPY   = 2'd0,
    KIND_BLEND  = 2'd1,
    KIND_RED    = 2'd2,
    KIND_SHADOW = 2'd3
  } kind_e;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BEGIN,
    ST_PIX_ADDR,
    ST_PIX_READ,
    ST_PIX_WRITE,
    ST_RD_ADDR,
    ST_RD_READ,
    ST_RD_OUT,
    ST_CLEAR
  } state_e;

  // configuration port
  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 15;
  localparam logic [CFG_INDEX_W-1:0] REG_CAMERA_X = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_CAMERA_Y = 1'b1;

  // stream widths
  localparam int unsigned IN_DATA_W  = 120;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 32;

  // pixel constants
  localparam logic [31:0] COLOR_MASK  = 32'h00ff_ffff;
  localparam logic [31:0] RED_MASK    = 32'h00ff_0000;
  localparam logic [31:0] SHADOW_MASK = 32'hf0f0_f0f0;
  localparam logic [31:0] WHITE_WORD  = 32'hffff_ffff;
  localparam logic [6:0]  PCT_MAX     = 7'd100;

  // drawn width = product / 100 as a reciprocal multiply
  localparam int unsigned DW_RECIP_W = 20;
  localparam int unsigned DW_SHIFT   = 26;
  localparam logic [DW_RECIP_W-1:0] DW_RECIP = 20'd671089;

  // shadow offset = channel sum / 20 as a reciprocal multiply
  localparam int unsigned SH_RECIP_W = 12;
  localparam int unsigned SH_SHIFT   = 16;
  localparam logic [SH_RECIP_W-1:0] SH_RECIP = 12'd3277;
  localparam int unsigned SH_K_W     = 6;

  // input item, last field in the lowest bits
  typedef struct packed {
    logic [4:0]  pad;
    logic [31:0] sprite_pixel;
    logic [1:0]  draw_kind;
    logic [6:0]  width_percent;
    logic [9:0]  center_y;
    logic [9:0]  center_x;
    logic [10:0] sprite_height;
    logic [10:0] sprite_width;
    logic [15:0] pos_y;
    logic [15:0] pos_x;
  } item_t;

  // controller to datapath commands
  typedef struct packed {
    logic begin_accept;
    logic drawn_calc;
    logic pixel_accept;
    logic read_accept;
    logic addr_calc;
    logic pix_read;
    logic rd_read;
    logic mem_write;
    logic clear_start;
    logic clear_step;
    logic out_load;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic hit;
    logic need_read;
    logic clear_last;
  } stat_t;

endpackage

`default_nettype wire

// File: rtl/core/cksb_ram.sv
// cksb_ram: generic single-port ram with registered read data
// no dependencies
`default_nettype none

module cksb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one access per cycle, write or read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/cksb_ctrl.sv
// cksb_ctrl: sequencing state machine of the blitter
// depends on cksb_pkg; drives cksb_dp through cmd_t and reads stat_t
`default_nettype none

module cksb_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire cksb_pkg::mode_e in_mode_i,
  output logic                 in_ready_o,
  input  wire logic            out_ready_i,
  output logic                 out_valid_o,
  output cksb_pkg::cmd_t       cmd_o,
  input  wire cksb_pkg::stat_t stat_i
);

  import cksb_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // state and output slot registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          unique case (in_mode_i)
            MODE_BEGIN: begin
              cmd_o.begin_accept = 1'b1;
              state_d            = ST_BEGIN;
            end
            MODE_PIXEL: begin
              cmd_o.pixel_accept = 1'b1;
              state_d            = ST_PIX_ADDR;
            end
            MODE_CLEAR: begin
              cmd_o.clear_start = 1'b1;
              state_d           = ST_CLEAR;
            end
            MODE_READ: begin
              cmd_o.read_accept = 1'b1;
              state_d           = ST_RD_ADDR;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_BEGIN: begin
        cmd_o.drawn_calc = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_PIX_ADDR: begin
        cmd_o.addr_calc = 1'b1;
        if (!stat_i.hit) begin
          state_d = ST_IDLE;
        end else if (stat_i.need_read) begin
          state_d = ST_PIX_READ;
        end else begin
          state_d = ST_PIX_WRITE;
        end
      end
      ST_PIX_READ: begin
        cmd_o.pix_read = 1'b1;
        state_d        = ST_PIX_WRITE;
      end
      ST_PIX_WRITE: begin
        cmd_o.mem_write = 1'b1;
        state_d         = ST_IDLE;
      end
      ST_RD_ADDR: begin
        cmd_o.addr_calc = 1'b1;
        state_d         = stat_i.hit ? ST_RD_READ : ST_RD_OUT;
      end
      ST_RD_READ: begin
        cmd_o.rd_read = 1'b1;
        state_d       = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        // wait for the output slot to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (stat_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output slot occupancy
  always_comb begin
    out_valid_d = (out_valid_q && !out_ready_i) || cmd_o.out_load;
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// File: rtl/core/cksb_dp.sv
// cksb_dp: sprite state, address arithmetic, pixel ops and the frame store
// depends on cksb_pkg and cksb_ram; commanded by cksb_ctrl
`default_nettype none

module cksb_dp #(
  parameter int unsigned SCREEN_WIDTH    = 256,
  parameter int unsigned SCREEN_HEIGHT   = 256,
  parameter int unsigned MAX_SPRITE_SIDE = 1024
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire cksb_pkg::item_t                      item_i,
  input  wire logic                                 cfg_we_i,
  input  wire logic [cksb_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  wire logic [cksb_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  wire cksb_pkg::cmd_t                       cmd_i,
  output cksb_pkg::stat_t                           stat_o,
  output logic [cksb_pkg::OUT_DATA_W-1:0]           read_data_o
);

  import cksb_pkg::*;

  localparam int unsigned COL_W       = $clog2(SCREEN_WIDTH);
  localparam int unsigned ROW_W       = $clog2(SCREEN_HEIGHT);
  localparam int unsigned STORE_WORDS = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int unsigned ADDR_W      = $clog2(STORE_WORDS);
  localparam int unsigned SIDE_W      = $clog2(MAX_SPRITE_SIDE + 1);
  localparam int unsigned CMP_W       = (SIDE_W > 11) ? SIDE_W : 11;
  localparam int unsigned PROD_W      = SIDE_W + 7;
  localparam int unsigned DWP_W       = PROD_W + DW_RECIP_W;
  localparam int unsigned ORG_W       = 18;
  localparam int unsigned POS_W       = 19;

  // configuration and sprite state
  logic [CFG_DATA_W-1:0] cam_x_q, cam_y_q;
  logic [ORG_W-1:0]      org_x_q, org_y_q;
  logic [SIDE_W-1:0]     fw_q, fh_q, dw_q, col_q, row_q;
  kind_e                 kind_q;

  // per item working registers
  logic [PROD_W-1:0]     prod_q;
  logic [31:0]           pix_q;
  logic [COL_W-1:0]      sx_q;
  logic [ROW_W-1:0]      sy_q;
  logic                  hit_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [SH_K_W-1:0]     k_q;
  logic [ADDR_W-1:0]     clr_q;
  logic [31:0]           out_q;

  // frame store port signals
  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_addr;
  logic [31:0]           ram_wdata, rdata;

  // begin decode: saturations and origin
  logic [CMP_W-1:0]      fw_ext, fh_ext;
  logic [SIDE_W-1:0]     fw_sat, fh_sat;
  logic [6:0]            pct_sat;
  logic [ORG_W-1:0]      org_x_d, org_y_d;

  always_comb begin
    fw_ext  = CMP_W'(item_i.sprite_width);
    fh_ext  = CMP_W'(item_i.sprite_height);
    fw_sat  = (fw_ext > CMP_W'(MAX_SPRITE_SIDE)) ? SIDE_W'(MAX_SPRITE_SIDE)
                                                 : SIDE_W'(fw_ext);
    fh_sat  = (fh_ext > CMP_W'(MAX_SPRITE_SIDE)) ? SIDE_W'(MAX_SPRITE_SIDE)
                                                 : SIDE_W'(fh_ext);
    pct_sat = (item_i.width_percent > PCT_MAX) ? PCT_MAX : item_i.width_percent;
    org_x_d = {{(ORG_W-16){item_i.pos_x[15]}}, item_i.pos_x}
            - ORG_W'(item_i.center_x) - ORG_W'(cam_x_q);
    org_y_d = {{(ORG_W-16){item_i.pos_y[15]}}, item_i.pos_y}
            - ORG_W'(item_i.center_y) - ORG_W'(cam_y_q);
  end

  // drawn width from the registered product
  logic [DWP_W-1:0] dw_prod;
  assign dw_prod = DWP_W'(prod_q) * DWP_W'(DW_RECIP);

  // pixel screen position and draw test
  logic              active, key_ok;
  logic [POS_W-1:0]  px, py, sx_src, sy_src;
  logic              on_screen;
  logic [SIDE_W:0]   col_inc;

  always_comb begin
    active  = (fw_q != '0) && (row_q < fh_q);
    key_ok  = (item_i.sprite_pixel & COLOR_MASK) != COLOR_MASK;
    px      = {org_x_q[ORG_W-1], org_x_q} + POS_W'(col_q);
    py      = {org_y_q[ORG_W-1], org_y_q} + POS_W'(row_q);
    if (cmd_i.read_accept) begin
      sx_src = {{(POS_W-16){item_i.pos_x[15]}}, item_i.pos_x};
      sy_src = {{(POS_W-16){item_i.pos_y[15]}}, item_i.pos_y};
    end else begin
      sx_src = px;
      sy_src = py;
    end
    on_screen = !sx_src[POS_W-1] && !sy_src[POS_W-1]
             && (sx_src < POS_W'(SCREEN_WIDTH)) && (sy_src < POS_W'(SCREEN_HEIGHT));
    col_inc = {1'b0, col_q} + (SIDE_W+1)'(1);
  end

  // shadow offset from the channel sum
  logic [9:0]                       ch_sum;
  logic [9+SH_RECIP_W:0]            k_prod;
  logic [ADDR_W:0]                  wrap_sum;
  logic [ADDR_W-1:0]                wrap_addr;

  always_comb begin
    ch_sum    = 10'(pix_q[23:16]) + 10'(pix_q[15:8]) + 10'(pix_q[7:0]);
    k_prod    = (10+SH_RECIP_W)'(ch_sum) * (10+SH_RECIP_W)'(SH_RECIP);
    wrap_sum  = (ADDR_W+1)'(addr_q) + (ADDR_W+1)'(k_q);
    wrap_addr = (wrap_sum >= (ADDR_W+1)'(STORE_WORDS))
              ? ADDR_W'(wrap_sum - (ADDR_W+1)'(STORE_WORDS))
              : ADDR_W'(wrap_sum);
  end

  // control state with reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0;
      cam_y_q <= '0;
      org_x_q <= '0;
      org_y_q <= '0;
      fw_q    <= '0;
      fh_q    <= '0;
      dw_q    <= '0;
      col_q   <= '0;
      row_q   <= '0;
      kind_q  <= KIND_COPY;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == REG_CAMERA_X) begin
          cam_x_q <= cfg_wdata_i;
        end else if (cfg_index_i == REG_CAMERA_Y) begin
          cam_y_q <= cfg_wdata_i;
        end
      end
      if (cmd_i.begin_accept) begin
        org_x_q <= org_x_d;
        org_y_q <= org_y_d;
        fw_q    <= fw_sat;
        fh_q    <= fh_sat;
        kind_q  <= kind_e'(item_i.draw_kind);
        col_q   <= '0;
        row_q   <= '0;
      end
      if (cmd_i.drawn_calc) begin
        dw_q <= SIDE_W'(dw_prod >> DW_SHIFT);
      end
      // raster walk over the full sprite
      if (cmd_i.pixel_accept && active) begin
        if (col_inc >= {1'b0, fw_q}) begin
          col_q <= '0;
          row_q <= row_q + SIDE_W'(1);
        end else begin
          col_q <= SIDE_W'(col_inc);
        end
      end
    end
  end

  // per item payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.begin_accept) begin
      prod_q <= PROD_W'(fw_sat) * PROD_W'(pct_sat);
    end
    if (cmd_i.pixel_accept || cmd_i.read_accept) begin
      pix_q <= item_i.sprite_pixel;
      sx_q  <= COL_W'(sx_src);
      sy_q  <= ROW_W'(sy_src);
      hit_q <= cmd_i.read_accept ? on_screen
             : (on_screen && key_ok && active && (col_q < dw_q));
    end
    if (cmd_i.addr_calc) begin
      addr_q <= ADDR_W'(sy_q) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(sx_q);
      k_q    <= SH_K_W'(k_prod >> SH_SHIFT);
    end
    if (cmd_i.clear_start) begin
      clr_q <= '0;
    end else if (cmd_i.clear_step) begin
      clr_q <= clr_q + ADDR_W'(1);
    end
    if (cmd_i.out_load) begin
      out_q <= hit_q ? rdata : '0;
    end
  end

  // frame store port
  always_comb begin
    ram_we   = cmd_i.mem_write || cmd_i.clear_step;
    ram_re   = cmd_i.pix_read || cmd_i.rd_read;
    ram_addr = addr_q;
    if (cmd_i.clear_step) begin
      ram_addr = clr_q;
    end else if (cmd_i.pix_read && (kind_q == KIND_SHADOW)) begin
      ram_addr = wrap_addr;
    end
  end

  // value written for a drawn pixel or a clear
  always_comb begin
    if (cmd_i.clear_step) begin
      ram_wdata = WHITE_WORD;
    end else begin
      unique case (kind_q)
        KIND_COPY:   ram_wdata = pix_q;
        KIND_BLEND:  ram_wdata = {8'h00,
                                  8'((9'(pix_q[23:16]) + 9'(rdata[23:16])) >> 1),
                                  8'((9'(pix_q[15:8])  + 9'(rdata[15:8]))  >> 1),
                                  8'((9'(pix_q[7:0])   + 9'(rdata[7:0]))   >> 1)};
        KIND_RED:    ram_wdata = pix_q | RED_MASK;
        KIND_SHADOW: ram_wdata = rdata & SHADOW_MASK;
        default:     ram_wdata = pix_q;
      endcase
    end
  end

  cksb_ram #(
    .WIDTH (32),
    .DEPTH (STORE_WORDS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (rdata)
  );

  // status back to the controller
  always_comb begin
    stat_o.hit        = hit_q;
    stat_o.need_read  = (kind_q == KIND_BLEND) || (kind_q == KIND_SHADOW);
    stat_o.clear_last = (clr_q == ADDR_W'(STORE_WORDS - 1));
  end

  assign read_data_o = out_q;

endmodule

`default_nettype wire

// File: rtl/core/color_keyed_sprite_blitter.sv
// color_keyed_sprite_blitter: top level of the colour-keyed sprite blitter
// depends on cksb_pkg, cksb_ctrl and cksb_dp (which holds cksb_ram)
`default_nettype none

// Colour-keyed 2D blitter over a SCREEN_WIDTH x SCREEN_HEIGHT frame store of
// 32-bit words held in one single-port ram. Requests are handled one at a time;
// a request is taken only when the previous one has finished its store work,
// and a finished read answer waits in an output register while the next
// request is taken. The scaled width of a begin is a registered multiply
// followed by a reciprocal multiply; a drawn blend or shadow pixel reads the
// store and then writes it through the single ram port; a read answer may wait
// for the output register; a clear writes one word per cycle over the whole
// store. The store is undefined after reset until written. Camera registers
// are to be written through the cfg port only while the block is idle; the
// block itself does not enforce this.
module color_keyed_sprite_blitter #(
  parameter int unsigned SCREEN_WIDTH    = 256,
  parameter int unsigned SCREEN_HEIGHT   = 256,
  parameter int unsigned MAX_SPRITE_SIDE = 1024
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  // camera register writes
  input  wire logic                                 cfg_we_i,
  input  wire logic [cksb_pkg::CFG_INDEX_W-1:0]     cfg_index_i,
  input  wire logic [cksb_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  // request stream
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // pos_x, pos_y, sprite_width, sprite_height, center_x, center_y,
  // width_percent, draw_kind, sprite_pixel, zero fill
  input  wire logic [cksb_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // mode
  input  wire logic [cksb_pkg::IN_USER_W-1:0]       s_axis_tuser,
  // answer stream
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // read_data
  output logic [cksb_pkg::OUT_DATA_W-1:0]           m_axis_tdata
);

  import cksb_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  item_t item;
  mode_e mode;

  assign item = item_t'(s_axis_tdata);
  assign mode = mode_e'(s_axis_tuser);

  cksb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_mode_i   (mode),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  cksb_dp #(
    .SCREEN_WIDTH    (SCREEN_WIDTH),
    .SCREEN_HEIGHT   (SCREEN_HEIGHT),
    .MAX_SPRITE_SIDE (MAX_SPRITE_SIDE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .read_data_o (m_axis_tdata)
  );

endmodule

`default_nettype wire

// File: bench/color_keyed_sprite_blitter_tb.sv
// color_keyed_sprite_blitter_tb: self-checking bench for the colour-keyed sprite blitter
// keeps its own frame store copy and checks every read answer against it
// depends on cksb_pkg and color_keyed_sprite_blitter
module color_keyed_sprite_blitter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cksb_pkg::*;

  localparam int          SCREEN_W      = 256;
  localparam int          SCREEN_H      = 256;
  localparam int          SPRITE_MAX    = 1024;
  localparam int unsigned SCREEN_PIXELS = SCREEN_W * SCREEN_H;
  localparam int          HOLD_CYCLES   = 500;
  localparam int          SETTLE_CYCLES = 16;

  // frame store shadow copy, blit state and queue of expected read answers
  class blit_checker;
    bit [31:0]   frame_mem [SCREEN_PIXELS];
    int unsigned cam_x, cam_y;
    int          org_x, org_y;
    int unsigned full_w, full_h, drawn_w, col_idx, row_idx;
    kind_e       kind = KIND_COPY;
    logic [31:0] pending_reads [$];
    int          fail_count;

    // apply one accepted request to the shadow state
    function void note_request(mode_e mode, item_t it);
      int unsigned pct, addr, shade;
      int          sx, sy, rx, ry;
      logic [31:0] pix, old, word;
      case (mode)
        MODE_BEGIN: begin
          pct = it.width_percent;
          if (pct > PCT_MAX) pct = PCT_MAX;
          org_x = $signed(it.pos_x) - int'(it.center_x) - int'(cam_x);
          org_y = $signed(it.pos_y) - int'(it.center_y) - int'(cam_y);
          full_w = (it.sprite_width > SPRITE_MAX) ? SPRITE_MAX : it.sprite_width;
          full_h = (it.sprite_height > SPRITE_MAX) ? SPRITE_MAX : it.sprite_height;
          drawn_w = full_w * pct / 100;
          kind = kind_e'(it.draw_kind);
          col_idx = 0;
          row_idx = 0;
        end
        MODE_PIXEL: begin
          // pixels beyond the sprite, or with an empty sprite, are dropped
          if (full_w != 0 && row_idx < full_h) begin
            pix = it.sprite_pixel;
            sx = org_x + int'(col_idx);
            sy = org_y + int'(row_idx);
            if ((pix & COLOR_MASK) != COLOR_MASK && col_idx < drawn_w &&
                sx >= 0 && sy >= 0 && sx < SCREEN_W && sy < SCREEN_H) begin
              addr = sy * SCREEN_W + sx;
              old = frame_mem[addr];
              case (kind)
                KIND_COPY: word = pix;
                KIND_BLEND: begin
                  word = '0;
                  word[23:16] = ({1'b0, pix[23:16]} + {1'b0, old[23:16]}) >> 1;
                  word[15:8]  = ({1'b0, pix[15:8]} + {1'b0, old[15:8]}) >> 1;
                  word[7:0]   = ({1'b0, pix[7:0]} + {1'b0, old[7:0]}) >> 1;
                end
                KIND_RED: word = pix | RED_MASK;
                default: begin
                  // shadow reads further on in the store, wrapping at the end
                  shade = (pix[23:16] + pix[15:8] + pix[7:0]) / 20;
                  word = frame_mem[(addr + shade) % SCREEN_PIXELS] & SHADOW_MASK;
                end
              endcase
              frame_mem[addr] = word;
            end
            col_idx++;
            if (col_idx >= full_w) begin
              col_idx = 0;
              row_idx++;
            end
          end
        end
        MODE_CLEAR: begin
          foreach (frame_mem[i]) frame_mem[i] = WHITE_WORD;
        end
        default: begin
          rx = $signed(it.pos_x);
          ry = $signed(it.pos_y);
          if (rx >= 0 && ry >= 0 && rx < SCREEN_W && ry < SCREEN_H)
            pending_reads.push_back(frame_mem[ry * SCREEN_W + rx]);
          else
            pending_reads.push_back(32'h0);
        end
      endcase
    endfunction

    // compare one answer with the oldest expected word
    function void check_read_data(logic [31:0] data);
      logic [31:0] want;
      if (pending_reads.size() == 0) begin
        $error("read_data: answer with no read pending, actual %h", data);
        fail_count++;
      end else begin
        want = pending_reads.pop_front();
        if (data !== want) begin
          $error("read_data mismatch: expected %h, actual %h", want, data);
          fail_count++;
        end
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_INDEX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_wdata_i = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_DATA_W-1:0]    s_axis_tdata = '0;
  logic [IN_USER_W-1:0]    s_axis_tuser = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   m_axis_tdata;

  blit_checker sb = new();

  int tx_idle_pct, rx_idle_pct;
  int hold_asked, hold_taken, hold_left;
  int cam_x_now, cam_y_now;
  int last_tx, last_ty;
  int run_items;

  color_keyed_sprite_blitter #(
    .SCREEN_WIDTH    (SCREEN_W),
    .SCREEN_HEIGHT   (SCREEN_H),
    .MAX_SPRITE_SIDE (SPRITE_MAX)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    // pos_x, pos_y, sprite_width, sprite_height, center_x, center_y,
    // width_percent, draw_kind, sprite_pixel, zero fill
    .s_axis_tdata  (s_axis_tdata),
    // mode
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    // read_data
    .m_axis_tdata  (m_axis_tdata)
  );

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // watch both handshakes
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.note_request(mode_e'(s_axis_tuser), item_t'(s_axis_tdata));
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_read_data(m_axis_tdata);
  end

  // answer side: random stalls plus one long hold-off on demand
  always @(posedge clk_i) begin
    if (hold_taken != hold_asked) begin
      hold_taken = hold_asked;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // run limit
  initial begin
    #10_000_000;
    $display("** color_keyed_sprite_blitter: FAILED **");
    $finish;
  end

  function automatic item_t rand_item();
    logic [127:0] raw;
    item_t        it;
    raw = {$urandom, $urandom, $urandom, $urandom};
    it = raw[119:0];
    it.pad = '0;
    return it;
  endfunction

  function automatic item_t begin_item(int px, int py, int w, int h, int cx, int cy,
                                       int pct, kind_e k);
    item_t it;
    it = rand_item();
    it.pos_x         = 16'(px);
    it.pos_y         = 16'(py);
    it.sprite_width  = 11'(w);
    it.sprite_height = 11'(h);
    it.center_x      = 10'(cx);
    it.center_y      = 10'(cy);
    it.width_percent = 7'(pct);
    it.draw_kind     = k;
    return it;
  endfunction

  // offer one request, with a random gap first, and wait for acceptance
  task automatic send_request(mode_e mode, item_t it);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= it;
    s_axis_tuser  <= mode;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic send_pixel(logic [31:0] pix);
    item_t it;
    it = rand_item();
    it.sprite_pixel = pix;
    send_request(MODE_PIXEL, it);
  endtask

  task automatic read_at(int x, int y);
    item_t it;
    it = rand_item();
    it.pos_x = 16'(x);
    it.pos_y = 16'(y);
    send_request(MODE_READ, it);
  endtask

  // both camera registers, written back to back while idle
  task automatic write_camera(int x, int y);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_CAMERA_X;
    cfg_wdata_i <= 15'(x);
    @(posedge clk_i);
    cfg_index_i <= REG_CAMERA_Y;
    cfg_wdata_i <= 15'(y);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.cam_x  = x;
    sb.cam_y  = y;
    cam_x_now = x;
    cam_y_now = y;
  endtask

  // stop offering and wait for all answers plus the block's own tail
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_reads.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // one sprite: begin, its pixels in raster order, then a few reads over it
  task automatic send_sprite_run();
    int    w, h, cx, cy, px, py, pct, n_pix, pick;
    kind_e k;
    logic [31:0] pix;
    pick = $urandom_range(0, 99);
    w    = $urandom_range(1, 12);
    h    = $urandom_range(1, 6);
    pct  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 127) : 100;
    k    = kind_e'($urandom_range(0, 3));
    if (pick < 6) begin
      // oversized width, narrow drawn part
      w = $urandom_range(SPRITE_MAX + 1, 2047);
      h = 1;
      pct = $urandom_range(0, 3);
      n_pix = SPRITE_MAX * pct / 100 + 4;
    end else if (pick < 9) begin
      // oversized height, cut short
      w = 1;
      h = $urandom_range(SPRITE_MAX + 1, 2047);
      n_pix = 8;
    end else if (pick < 17) begin
      // empty sprite, its pixels are dropped
      if ($urandom_range(0, 1)) w = 0;
      else h = 0;
      n_pix = $urandom_range(1, 3);
    end else begin
      n_pix = w * h;
      if ($urandom_range(0, 9) == 0) n_pix = $urandom_range(0, n_pix - 1);
      else if ($urandom_range(0, 11) == 0) n_pix += $urandom_range(1, 3);
    end
    cx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
    cy = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
    last_tx = $urandom_range(0, 275) - 12;
    last_ty = $urandom_range(0, 271) - 8;
    px = last_tx + cx + cam_x_now;
    py = last_ty + cy + cam_y_now;
    // a far camera cannot be reached from the top of the position range
    if (px > 32767) begin
      cx = $urandom_range(0, 8);
      px = 32767;
      last_tx = px - cx - cam_x_now;
    end
    if (py > 32767) begin
      cy = $urandom_range(0, 4);
      py = 32767;
      last_ty = py - cy - cam_y_now;
    end
    send_request(MODE_BEGIN, begin_item(px, py, w, h, cx, cy, pct, k));
    repeat (n_pix) begin
      if ($urandom_range(0, 4) == 0) pix = {8'($urandom), 24'hff_ffff};
      else pix = $urandom;
      send_pixel(pix);
    end
    run_items += 1 + n_pix;
    repeat ($urandom_range(1, 3)) begin
      read_at(last_tx + $urandom_range(0, 13), last_ty + $urandom_range(0, 6));
      run_items++;
    end
  endtask

  // random traffic: mostly whole sprites, some lone reads, some noise, one clear if asked
  task automatic run_phase(int n_items, int tx_pct, int rx_pct, bit with_clear);
    int    start, pick;
    bit    cleared;
    mode_e mode;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start   = run_items;
    cleared = !with_clear;
    while (run_items - start < n_items) begin
      pick = $urandom_range(0, 99);
      if (!cleared && run_items - start > n_items / 2) begin
        send_request(MODE_CLEAR, rand_item());
        cleared = 1'b1;
        run_items++;
      end else if (pick < 65) begin
        send_sprite_run();
      end else if (pick < 85) begin
        read_at(last_tx + $urandom_range(0, 13), last_ty + $urandom_range(0, 6));
        run_items++;
      end else begin
        mode = mode_e'($urandom_range(0, 3));
        if (mode == MODE_CLEAR) mode = MODE_READ;
        send_request(mode, rand_item());
        run_items++;
      end
    end
    // end on answers so the drain sees the last of the store work
    repeat (3) begin
      read_at($urandom_range(0, SCREEN_W - 1), $urandom_range(0, SCREEN_H - 1));
      run_items++;
    end
    drain();
  endtask

  initial begin
    tx_idle_pct = 11;
    rx_idle_pct = 62;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_camera(0, 0);

    // pixel before any sprite and a read off screen, then wipe the store
    send_pixel(32'h0011_2233);
    read_at(-1, 300);
    send_request(MODE_CLEAR, rand_item());

    // copy at the right edge: percent above 100, keyed white, clipped, extra
    send_request(MODE_BEGIN, begin_item(254, 0, 4, 1, 0, 0, 127, KIND_COPY));
    send_pixel(32'h1234_5678);
    send_pixel(32'haaff_ffff);
    send_pixel(32'h0102_0304);
    send_pixel(32'h0506_0708);
    send_pixel(32'h0a0b_0c0d);

    // shadow on the last word, oversized width, offset read wraps to the start
    send_request(MODE_BEGIN, begin_item(255, 255, 2000, 1, 0, 0, 1, KIND_SHADOW));
    send_pixel(32'h00ff_fffe);

    // blend at the top-left corner, three of four pixels off screen
    send_request(MODE_BEGIN, begin_item(0, 0, 2, 2, 1, 1, 100, KIND_BLEND));
    send_pixel(32'h8040_2010);
    send_pixel(32'h1122_3344);
    send_pixel(32'h5566_7788);
    send_pixel(32'h0080_4021);

    // red tint, after empty sprites of zero width and zero height
    send_request(MODE_BEGIN, begin_item(5, 5, 0, 3, 0, 0, 100, KIND_RED));
    send_pixel(32'h0fed_cba9);
    send_request(MODE_BEGIN, begin_item(5, 5, 1, 0, 0, 0, 100, KIND_RED));
    send_pixel(32'h0fed_cba9);
    send_request(MODE_BEGIN, begin_item(5, 5, 1, 1, 0, 0, 100, KIND_RED));
    send_pixel(32'h0102_0304);

    read_at(254, 0);
    read_at(0, 0);
    read_at(255, 255);
    read_at(5, 5);
    read_at(-32768, 32767);
    drain();

    write_camera($urandom_range(0, 32767), $urandom_range(0, 32767));
    run_phase(225, 11, 62, 1'b1);
    write_camera($urandom_range(0, 32767), $urandom_range(0, 32767));
    run_phase(225, 62, 11, 1'b1);

    // far camera, no idling, and a long stall on the answer side
    write_camera(32767, 32767);
    hold_asked++;
    run_phase(60, 0, 0, 1'b0);

    if (sb.fail_count == 0)
      $display("** color_keyed_sprite_blitter: PASSED **");
    else
      $display("** color_keyed_sprite_blitter: FAILED **");
    $finish;
  end

endmodule

// File: color_keyed_sprite_blitter.f
rtl/core/cksb_pkg.sv
rtl/core/cksb_ram.sv
rtl/core/cksb_ctrl.sv
rtl/core/cksb_dp.sv
rtl/core/color_keyed_sprite_blitter.sv
bench/color_keyed_sprite_blitter_tb.sv
